>>> hdl/smtp_pkg.sv
// Shared types, codes and line-parsing functions for the SMTP session command block.
package smtp_pkg;

    localparam logic [7:0] MAX_RCPT = 8'd128;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;

    localparam logic [39:0] TAIL_END = 40'h0D0A2E0D0A;
    localparam logic [39:0] TAIL_START = 40'h000000_0D0A;

    localparam logic [79:0] LIT_QUIT = {"QUIT", 48'h0};
    localparam logic [79:0] LIT_DATA = {"DATA", 48'h0};
    localparam logic [79:0] LIT_RSET = {"RSET", 48'h0};
    localparam logic [79:0] LIT_NOOP = {"NOOP", 48'h0};
    localparam logic [79:0] LIT_HELO = {"HELO ", 40'h0};
    localparam logic [79:0] LIT_TITLE = {"TITLE ", 32'h0};
    localparam logic [79:0] LIT_RCPT = {"RCPT TO:", 16'h0};
    localparam logic [79:0] LIT_MAIL = "MAIL FROM:";

    typedef enum logic [4:0] {
        PH_NEW    = 5'b00001,
        PH_READY  = 5'b00010,
        PH_TRANS  = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_CLOSED = 5'b10000
    } phase_t;

    typedef enum logic [3:0] {
        K_GREET   = 4'd0,
        K_OK      = 4'd1,
        K_BYE     = 4'd2,
        K_START   = 4'd3,
        K_UNKNOWN = 4'd4,
        K_BRACKET = 4'd5,
        K_SENDER  = 4'd6,
        K_ORDER   = 4'd7,
        K_NORCPT  = 4'd8,
        K_RCPTBAD = 4'd9,
        K_FULL    = 4'd10
    } kind_t;

    typedef enum logic [3:0] {
        C_HELO, C_MAIL, C_RCPT, C_DATA, C_QUIT, C_RSET, C_NOOP, C_UNKNOWN, C_TITLE
    } cmd_t;

    typedef struct packed {
        logic [3:0]      len;
        logic [9:0][7:0] kw;
        logic            br;
        logic [3:0]      scan;
    } line_t;

    typedef struct packed {
        kind_t      kind;
        logic       done;
        logic [7:0] rcpts;
        logic       closed;
    } reply_t;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
    endfunction

    function automatic logic prefix_ok(input logic [9:0][7:0] kw, input logic [79:0] lit,
                                       input int n);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 10; i++) begin
            if (i < n && upcase(kw[i]) != lit[79 - 8 * i -: 8])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [3:0] scan_addr(input logic [3:0] s, input logic [7:0] b,
                                             input logic first);
        logic [3:0] r;
        r = s;
        if (!s[0])
        begin
            if (b == CH_GT)
            begin
                r[0] = 1'b1;
            end
            else if (!s[1])
            begin
                if (b == CH_AT)
                begin
                    r[1] = 1'b1;
                    r[2] = first;
                end
            end
            else
            begin
                r[3] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic line_t add_byte(input line_t s, input logic [7:0] b);
        line_t r;
        logic  rc;
        logic  ml;
        r = s;
        if (s.len < 4'd10)
        begin
            r.kw[s.len] = b;
        end
        rc = prefix_ok(r.kw, LIT_RCPT, 8);
        ml = prefix_ok(r.kw, LIT_MAIL, 10);
        if (s.len == 4'd8 && rc)
        begin
            r.br = (b == CH_LT);
        end
        if (s.len == 4'd10 && ml)
        begin
            r.br = (b == CH_LT);
        end
        if (s.len >= 4'd9 && rc)
        begin
            r.scan = scan_addr(s.scan, b, s.len == 4'd9);
        end
        else if (s.len >= 4'd11 && ml)
        begin
            r.scan = scan_addr(s.scan, b, s.len == 4'd11);
        end
        if (s.len != 4'd15)
        begin
            r.len = s.len + 4'd1;
        end
        return r;
    endfunction

    function automatic cmd_t classify(input line_t s);
        cmd_t c;
        c = C_UNKNOWN;
        if (s.len > 4'd10 && prefix_ok(s.kw, LIT_MAIL, 10))
        begin
            c = C_MAIL;
        end
        if (s.len > 4'd8 && prefix_ok(s.kw, LIT_RCPT, 8))
        begin
            c = C_RCPT;
        end
        if (s.len > 4'd5 && prefix_ok(s.kw, LIT_TITLE, 6))
        begin
            c = C_TITLE;
        end
        if (s.len > 4'd5 && prefix_ok(s.kw, LIT_HELO, 5))
        begin
            c = C_HELO;
        end
        if (s.len == 4'd4)
        begin
            if (prefix_ok(s.kw, LIT_QUIT, 4))
            begin
                c = C_QUIT;
            end
            else if (prefix_ok(s.kw, LIT_DATA, 4))
            begin
                c = C_DATA;
            end
            else if (prefix_ok(s.kw, LIT_RSET, 4))
            begin
                c = C_RSET;
            end
            else if (prefix_ok(s.kw, LIT_NOOP, 4))
            begin
                c = C_NOOP;
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/smtp_in_if.sv
// Input channel interface: client bytes and session-start markers.
interface smtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       session_start;

    modport source (output valid, output rx_byte, output session_start, input ready);
    modport sink (input valid, input rx_byte, input session_start, output ready);
endinterface

>>> hdl/smtp_out_if.sv
// Output channel interface: one reply per transfer.
interface smtp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] reply_kind;
    logic       message_done;
    logic [7:0] recipients;
    logic       session_closed;

    modport source (output valid, output reply_kind, output message_done,
                    output recipients, output session_closed, input ready);
    modport sink (input valid, input reply_kind, input message_done,
                  input recipients, input session_closed, output ready);
endinterface

>>> hdl/smtp_front.sv
// Front end: per-byte line assembly, command classification and session phase tracking.
module smtp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          rx_byte,
    input  logic                session_start,
    output logic                ev_valid,
    output smtp_pkg::reply_t    ev
);

    smtp_pkg::phase_t phase_reg, phase_next;
    smtp_pkg::line_t  line_reg, line_next;
    logic             pend_reg, pend_next;
    logic [7:0]       count_reg, count_next;
    logic [39:0]      tail_reg, tail_next;

    smtp_pkg::line_t  s1;
    smtp_pkg::cmd_t   cmd;
    logic [39:0]      tail_sh;
    logic             addr_ok;

    always_comb
    begin
        phase_next = phase_reg;
        line_next  = line_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        tail_next  = tail_reg;
        ev_valid   = 1'b0;
        ev         = '{kind: smtp_pkg::K_OK, done: 1'b0, rcpts: count_reg, closed: 1'b0};
        s1         = pend_reg ? smtp_pkg::add_byte(line_reg, smtp_pkg::CH_CR) : line_reg;
        cmd        = smtp_pkg::classify(line_reg);
        tail_sh    = {tail_reg[31:0], rx_byte};
        addr_ok    = line_reg.scan[1] && !line_reg.scan[2] && line_reg.scan[3];
        if (session_start)
        begin
            phase_next = smtp_pkg::PH_NEW;
            line_next  = '0;
            pend_next  = 1'b0;
            count_next = '0;
            tail_next  = '0;
            ev_valid   = 1'b1;
            ev.kind    = smtp_pkg::K_GREET;
            ev.rcpts   = '0;
        end
        else if (phase_reg == smtp_pkg::PH_CLOSED)
        begin
            ev_valid = 1'b0;
        end
        else if (phase_reg == smtp_pkg::PH_DATA)
        begin
            tail_next = tail_sh;
            if (tail_sh == smtp_pkg::TAIL_END)
            begin
                ev_valid   = 1'b1;
                ev.done    = 1'b1;
                count_next = '0;
                phase_next = smtp_pkg::PH_READY;
                tail_next  = '0;
                line_next  = '{len: 4'd0, kw: line_reg.kw, br: 1'b0, scan: 4'd0};
                pend_next  = 1'b0;
            end
        end
        else if (pend_reg && rx_byte == smtp_pkg::CH_LF)
        begin
            ev_valid  = 1'b1;
            pend_next = 1'b0;
            line_next = '{len: 4'd0, kw: line_reg.kw, br: 1'b0, scan: 4'd0};
            if (cmd == smtp_pkg::C_QUIT && phase_reg != smtp_pkg::PH_NEW)
            begin
                phase_next = smtp_pkg::PH_CLOSED;
                ev.kind    = smtp_pkg::K_BYE;
                ev.closed  = 1'b1;
            end
            else if (cmd == smtp_pkg::C_UNKNOWN)
            begin
                ev.kind = smtp_pkg::K_UNKNOWN;
            end
            else if (phase_reg == smtp_pkg::PH_NEW)
            begin
                if (cmd == smtp_pkg::C_HELO)
                begin
                    phase_next = smtp_pkg::PH_READY;
                end
                else
                begin
                    ev.kind = smtp_pkg::K_ORDER;
                end
            end
            else if (cmd == smtp_pkg::C_NOOP)
            begin
                ev.kind = smtp_pkg::K_OK;
            end
            else if (cmd == smtp_pkg::C_RSET)
            begin
                count_next = '0;
                ev.rcpts   = '0;
                phase_next = smtp_pkg::PH_READY;
            end
            else if (phase_reg == smtp_pkg::PH_READY)
            begin
                if (cmd == smtp_pkg::C_MAIL)
                begin
                    if (!line_reg.br)
                    begin
                        ev.kind = smtp_pkg::K_BRACKET;
                    end
                    else if (!addr_ok)
                    begin
                        ev.kind = smtp_pkg::K_SENDER;
                    end
                    else
                    begin
                        phase_next = smtp_pkg::PH_TRANS;
                    end
                end
                else
                begin
                    ev.kind = smtp_pkg::K_ORDER;
                end
            end
            else if (cmd == smtp_pkg::C_RCPT)
            begin
                if (!line_reg.br)
                begin
                    ev.kind = smtp_pkg::K_BRACKET;
                end
                else if (!addr_ok)
                begin
                    ev.kind = smtp_pkg::K_RCPTBAD;
                end
                else if (count_reg >= smtp_pkg::MAX_RCPT)
                begin
                    ev.kind = smtp_pkg::K_FULL;
                end
                else
                begin
                    count_next = count_reg + 8'd1;
                    ev.rcpts   = count_reg + 8'd1;
                end
            end
            else if (cmd == smtp_pkg::C_TITLE)
            begin
                ev.kind = smtp_pkg::K_OK;
            end
            else if (cmd == smtp_pkg::C_DATA)
            begin
                if (count_reg == 8'd0)
                begin
                    ev.kind = smtp_pkg::K_NORCPT;
                end
                else
                begin
                    phase_next = smtp_pkg::PH_DATA;
                    tail_next  = smtp_pkg::TAIL_START;
                    ev.kind    = smtp_pkg::K_START;
                end
            end
            else
            begin
                ev.kind = smtp_pkg::K_ORDER;
            end
        end
        else if (rx_byte == smtp_pkg::CH_CR)
        begin
            pend_next = 1'b1;
            line_next = s1;
        end
        else
        begin
            pend_next = 1'b0;
            line_next = smtp_pkg::add_byte(s1, rx_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= smtp_pkg::PH_NEW;
            line_reg  <= '0;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            tail_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

>>> hdl/smtp_queue.sv
// Back end: two-entry reply queue that drives the output channel.
module smtp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  smtp_pkg::reply_t wr_data,
    output logic             full,
    output logic             rd_valid,
    input  logic             rd_ready,
    output smtp_pkg::reply_t rd_data
);

    smtp_pkg::reply_t mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       cnt_reg;
    logic             rd;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd       = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

>>> hdl/smtp_session_command_fsm.sv
// Top level of the SMTP session command block.
// The rx channel carries one client byte per transfer, or a session-start marker
// (session_start high, byte ignored) that resets the session and yields the
// greeting. The tx channel carries one reply per transfer: reply kind, message-done
// flag, recipient count and the session-closed flag. A reply is produced for each
// CR LF ended line outside the data and closed phases, for the end of a message
// body and for each session start; other bytes produce no reply.
// A byte is taken every cycle while the two-entry reply queue has room. The front
// end updates all session state in the cycle a byte is accepted, so a reply enters
// the reply queue as its byte is accepted and shows on tx once the replies ahead of
// it have been taken. Sustained rate is one byte per cycle while the queue has room,
// as the front end handles each byte combinationally. When the receiver stalls,
// replies collect in the queue; rx ready drops only when both entries are occupied.
// Reset puts the session in the new phase with no recipients and an empty queue.
module smtp_session_command_fsm (
    input  logic       clk,
    input  logic       rst_n,
    smtp_in_if.sink    rx,
    smtp_out_if.source tx
);

    logic             fire;
    logic             ev_valid;
    logic             full;
    smtp_pkg::reply_t ev;
    smtp_pkg::reply_t head;

    assign rx.ready = !full;
    assign fire     = rx.valid && !full;

    smtp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .rx_byte       (rx.rx_byte),
        .session_start (rx.session_start),
        .ev_valid      (ev_valid),
        .ev            (ev)
    );

    smtp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (fire && ev_valid),
        .wr_data  (ev),
        .full     (full),
        .rd_valid (tx.valid),
        .rd_ready (tx.ready),
        .rd_data  (head)
    );

    assign tx.reply_kind     = head.kind;
    assign tx.message_done   = head.done;
    assign tx.recipients     = head.rcpts;
    assign tx.session_closed = head.closed;

endmodule

>>> hdl/smtp_checker.sv
// Port-level assertions for the SMTP session command block, bound to the top level.
module smtp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_start,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] reply_kind,
    input logic       message_done,
    input logic [7:0] recipients,
    input logic       session_closed
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Reply withdrawn before transfer.");

    a_greet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_start |=> out_valid)
        else $error("Session start gave no pending reply.");

    a_bye: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && session_closed |-> reply_kind == smtp_pkg::K_BYE)
        else $error("Closed flag on a reply other than bye.");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_done |-> reply_kind == smtp_pkg::K_OK && !session_closed)
        else $error("Message end reply is malformed.");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == smtp_pkg::K_GREET |-> recipients == 8'd0)
        else $error("Greeting carries a recipient count.");

endmodule

bind smtp_session_command_fsm smtp_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (rx.valid),
    .in_ready       (rx.ready),
    .in_start       (rx.session_start),
    .out_valid      (tx.valid),
    .out_ready      (tx.ready),
    .reply_kind     (tx.reply_kind),
    .message_done   (tx.message_done),
    .recipients     (tx.recipients),
    .session_closed (tx.session_closed)
);

>>> sim/smtp_tb_if.sv
`timescale 1ns / 1ps
// Testbench copies of the channel interfaces are not needed; this file holds the reply record and the rx item record.
package smtp_tb_pkg;

    typedef struct {
        logic [3:0] kind;
        logic       done;
        logic [7:0] rcpts;
        logic       closed;
    } reply_rec_t;

    typedef struct {
        logic [7:0] b;
        logic       start;
    } rx_item_t;

endpackage

>>> sim/smtp_session_command_fsm_tb.sv
`timescale 1ns / 1ps
// Testbench for the SMTP session command block: scripted sessions and random bytes, checked against a predictor.
module smtp_session_command_fsm_tb;

    logic clk;
    logic rst_n;
    int   errors;
    int   queued;
    int   rx_idle_pct;
    int   tx_idle_pct;
    logic hold_rx;

    smtp_in_if  rx ();
    smtp_out_if tx ();

    smtp_session_command_fsm u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx.sink),
        .tx    (tx.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    smtp_tb_pkg::rx_item_t   pending_bytes[$];
    smtp_tb_pkg::reply_rec_t expected_replies[$];

    // Session model.
    logic [2:0]  m_phase;
    logic [3:0]  m_len;
    logic [7:0]  m_kw[10];
    logic        m_cr;
    logic        m_br;
    logic [3:0]  m_scan;
    logic [7:0]  m_rcpt;
    logic [39:0] m_tail;

    localparam logic [2:0] S_NEW = 3'd0, S_READY = 3'd1, S_TRANS = 3'd2, S_DATA = 3'd3,
                           S_CLOSED = 3'd4;

    function automatic logic [7:0] to_upper(logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction

    function automatic logic starts_with(logic [79:0] lit, int n);
        for (int i = 0; i < n; i++)
        begin
            if (to_upper(m_kw[i]) != lit[79 - 8 * i -: 8])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic clear_line_state();
        m_len = '0;
        m_cr = 1'b0;
        m_br = 1'b0;
        m_scan = '0;
    endtask

    task automatic reset_session();
        m_phase = S_NEW;
        clear_line_state();
        for (int i = 0; i < 10; i++)
        begin
            m_kw[i] = 8'h00;
        end
        m_rcpt = '0;
        m_tail = '0;
    endtask

    task automatic track_address(logic [7:0] b, logic first);
        if (!m_scan[0])
        begin
            if (b == ">")
            begin
                m_scan[0] = 1'b1;
            end
            else if (!m_scan[1])
            begin
                if (b == "@")
                begin
                    m_scan[1] = 1'b1;
                    if (first)
                    begin
                        m_scan[2] = 1'b1;
                    end
                end
            end
            else
            begin
                m_scan[3] = 1'b1;
            end
        end
    endtask

    task automatic append_byte(logic [7:0] b);
        int idx;
        idx = m_len;
        if (idx < 10)
        begin
            m_kw[idx] = b;
        end
        if (idx == 8 && starts_with(smtp_pkg::LIT_RCPT, 8))
        begin
            m_br = (b == "<");
        end
        if (idx == 10 && starts_with(smtp_pkg::LIT_MAIL, 10))
        begin
            m_br = (b == "<");
        end
        if (idx >= 9 && starts_with(smtp_pkg::LIT_RCPT, 8))
        begin
            track_address(b, idx == 9);
        end
        else if (idx >= 11 && starts_with(smtp_pkg::LIT_MAIL, 10))
        begin
            track_address(b, idx == 11);
        end
        if (m_len < 15)
        begin
            m_len++;
        end
    endtask

    function automatic smtp_pkg::cmd_t line_command();
        if (m_len == 4)
        begin
            if (starts_with(smtp_pkg::LIT_QUIT, 4)) return smtp_pkg::C_QUIT;
            if (starts_with(smtp_pkg::LIT_DATA, 4)) return smtp_pkg::C_DATA;
            if (starts_with(smtp_pkg::LIT_RSET, 4)) return smtp_pkg::C_RSET;
            if (starts_with(smtp_pkg::LIT_NOOP, 4)) return smtp_pkg::C_NOOP;
        end
        if (m_len > 5 && starts_with(smtp_pkg::LIT_HELO, 5)) return smtp_pkg::C_HELO;
        if (m_len > 5 && starts_with(smtp_pkg::LIT_TITLE, 6)) return smtp_pkg::C_TITLE;
        if (m_len > 8 && starts_with(smtp_pkg::LIT_RCPT, 8)) return smtp_pkg::C_RCPT;
        if (m_len > 10 && starts_with(smtp_pkg::LIT_MAIL, 10)) return smtp_pkg::C_MAIL;
        return smtp_pkg::C_UNKNOWN;
    endfunction

    task automatic push_reply(smtp_pkg::kind_t k, logic d, logic c);
        smtp_tb_pkg::reply_rec_t r;
        r.kind = k;
        r.done = d;
        r.rcpts = m_rcpt;
        r.closed = c;
        expected_replies.insert(expected_replies.size(), r);
    endtask

    task automatic finish_line();
        smtp_pkg::cmd_t  cmd;
        logic            addr_ok;
        logic            br;
        smtp_pkg::kind_t k;
        cmd = line_command();
        addr_ok = m_scan[1] && !m_scan[2] && m_scan[3];
        br = m_br;
        clear_line_state();
        if (cmd == smtp_pkg::C_QUIT && m_phase != S_NEW)
        begin
            m_phase = S_CLOSED;
            push_reply(smtp_pkg::K_BYE, 1'b0, 1'b1);
            return;
        end
        if (cmd == smtp_pkg::C_UNKNOWN)
        begin
            push_reply(smtp_pkg::K_UNKNOWN, 1'b0, 1'b0);
            return;
        end
        if (m_phase == S_NEW)
        begin
            if (cmd == smtp_pkg::C_HELO)
            begin
                m_phase = S_READY;
                k = smtp_pkg::K_OK;
            end
            else
            begin
                k = smtp_pkg::K_ORDER;
            end
        end
        else if (cmd == smtp_pkg::C_NOOP)
        begin
            k = smtp_pkg::K_OK;
        end
        else if (cmd == smtp_pkg::C_RSET)
        begin
            m_rcpt = '0;
            m_phase = S_READY;
            k = smtp_pkg::K_OK;
        end
        else if (m_phase == S_READY)
        begin
            if (cmd != smtp_pkg::C_MAIL) k = smtp_pkg::K_ORDER;
            else if (!br) k = smtp_pkg::K_BRACKET;
            else if (!addr_ok) k = smtp_pkg::K_SENDER;
            else
            begin
                m_phase = S_TRANS;
                k = smtp_pkg::K_OK;
            end
        end
        else if (cmd == smtp_pkg::C_RCPT)
        begin
            if (!br) k = smtp_pkg::K_BRACKET;
            else if (!addr_ok) k = smtp_pkg::K_RCPTBAD;
            else if (m_rcpt >= smtp_pkg::MAX_RCPT) k = smtp_pkg::K_FULL;
            else
            begin
                m_rcpt++;
                k = smtp_pkg::K_OK;
            end
        end
        else if (cmd == smtp_pkg::C_TITLE)
        begin
            k = smtp_pkg::K_OK;
        end
        else if (cmd == smtp_pkg::C_DATA)
        begin
            if (m_rcpt < 1) k = smtp_pkg::K_NORCPT;
            else
            begin
                m_phase = S_DATA;
                m_tail = smtp_pkg::TAIL_START;
                k = smtp_pkg::K_START;
            end
        end
        else
        begin
            k = smtp_pkg::K_ORDER;
        end
        push_reply(k, 1'b0, 1'b0);
    endtask

    task automatic predict_transfer(smtp_tb_pkg::rx_item_t it);
        if (it.start)
        begin
            reset_session();
            push_reply(smtp_pkg::K_GREET, 1'b0, 1'b0);
            return;
        end
        if (m_phase == S_CLOSED)
        begin
            return;
        end
        if (m_phase == S_DATA)
        begin
            m_tail = {m_tail[31:0], it.b};
            if (m_tail == smtp_pkg::TAIL_END)
            begin
                push_reply(smtp_pkg::K_OK, 1'b1, 1'b0);
                m_rcpt = '0;
                m_phase = S_READY;
                m_tail = '0;
                clear_line_state();
            end
            return;
        end
        if (m_cr)
        begin
            m_cr = 1'b0;
            if (it.b == smtp_pkg::CH_LF)
            begin
                finish_line();
                return;
            end
            append_byte(smtp_pkg::CH_CR);
        end
        if (it.b == smtp_pkg::CH_CR)
        begin
            m_cr = 1'b1;
        end
        else
        begin
            append_byte(it.b);
        end
    endtask

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx.valid <= 1'b0;
            rx.rx_byte <= 8'h00;
            rx.session_start <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                smtp_tb_pkg::rx_item_t acc;
                acc.b = rx.rx_byte;
                acc.start = rx.session_start;
                predict_transfer(acc);
            end
            if (!rx.valid || rx.ready)
            begin
                if (pending_bytes.size() > 0 && !hold_rx
                    && $urandom_range(99) >= rx_idle_pct)
                begin
                    smtp_tb_pkg::rx_item_t nx;
                    nx = pending_bytes.pop_front();
                    rx.valid <= 1'b1;
                    rx.rx_byte <= nx.b;
                    rx.session_start <= nx.start;
                end
                else
                begin
                    rx.valid <= 1'b0;
                    rx.rx_byte <= 8'($urandom_range(255));
                    rx.session_start <= 1'($urandom_range(1));
                end
            end
        end
    end

    // Monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx.ready <= 1'b0;
        end
        else
        begin
            if (tx.valid && tx.ready)
            begin
                smtp_tb_pkg::reply_rec_t e;
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: expected no reply, actual kind=%0d", $time, tx.reply_kind);
                    errors++;
                end
                else
                begin
                    e = expected_replies.pop_front();
                    if (tx.reply_kind !== e.kind || tx.message_done !== e.done
                        || tx.recipients !== e.rcpts || tx.session_closed !== e.closed)
                    begin
                        $display("%0t: expected kind=%0d done=%0b rcpt=%0d closed=%0b,",
                                 $time, e.kind, e.done, e.rcpts, e.closed,
                                 " actual kind=%0d done=%0b rcpt=%0d closed=%0b",
                                 tx.reply_kind, tx.message_done, tx.recipients,
                                 tx.session_closed);
                        errors++;
                    end
                end
            end
            tx.ready <= ($urandom_range(99) >= tx_idle_pct);
        end
    end

    task automatic enqueue_item(smtp_tb_pkg::rx_item_t it);
        pending_bytes.insert(pending_bytes.size(), it);
        queued++;
    endtask

    task automatic queue_start();
        smtp_tb_pkg::rx_item_t it;
        it.b = 8'($urandom_range(255));
        it.start = 1'b1;
        enqueue_item(it);
    endtask

    task automatic queue_text(string s);
        smtp_tb_pkg::rx_item_t it;
        it.start = 1'b0;
        for (int i = 0; i < s.len(); i++)
        begin
            it.b = s[i];
            enqueue_item(it);
        end
    endtask

    task automatic queue_line(string s);
        queue_text({s, "\r\n"});
    endtask

    function automatic string random_case(string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
        begin
            if (r[i] >= "A" && r[i] <= "Z" && $urandom_range(1))
            begin
                r[i] = r[i] + 8'd32;
            end
        end
        return r;
    endfunction

    function automatic string random_word(int n);
        string r;
        r = "";
        for (int i = 0; i < n; i++)
        begin
            r = {r, string'(byte'($urandom_range(8'h21, 8'h7E)))};
        end
        return r;
    endfunction

    function automatic string random_address();
        case ($urandom_range(9))
            0: return "<@host>";
            1: return "<user@>";
            2: return "<userhost>";
            3: return "user@host>";
            4: return "<u@h";
            default: return {"<", random_word($urandom_range(1, 4)), "@",
                             random_word($urandom_range(1, 4)), ">"};
        endcase
    endfunction

    task automatic queue_random_line();
        case ($urandom_range(11))
            0: queue_line(random_case("HELO x"));
            1: queue_line({random_case("MAIL FROM:"), random_address()});
            2, 3: queue_line({random_case("RCPT TO:"), random_address()});
            4: queue_line(random_case("DATA"));
            5: queue_line(random_case("NOOP"));
            6: queue_line(random_case("RSET"));
            7: queue_line({random_case("TITLE "), random_word(3)});
            8: queue_line(random_word($urandom_range(0, 6)));
            9: queue_text("\r\r\n");
            10: queue_line(random_case("QUIT"));
            default:
            begin
                queue_text(random_word(3));
                queue_text("\r");
                queue_line(random_word(2));
            end
        endcase
    endtask

    task automatic queue_random_byte();
        smtp_tb_pkg::rx_item_t it;
        it.start = 1'b0;
        it.b = 8'($urandom_range(255));
        enqueue_item(it);
    endtask

    task automatic queue_session();
        queue_start();
        queue_line(random_case("HELO host"));
        queue_line(random_case("MAIL FROM:<a@b>"));
        for (int i = $urandom_range(1, 3); i > 0; i--)
        begin
            queue_line({random_case("RCPT TO:"), random_address()});
        end
        queue_line(random_case("DATA"));
        queue_text(random_word($urandom_range(0, 8)));
        queue_text("\r\n.\r\n");
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || rx.valid || expected_replies.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        queued = 0;
        hold_rx = 1'b0;
        rx_idle_pct = 28;
        tx_idle_pct = 28;
        reset_session();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Commands before any session start, then a session with errors, a message and input after QUIT.
        queue_line("NOOP");
        queue_line("helo a");
        queue_start();
        queue_line("QUIT");
        queue_line("DATA");
        queue_line("Helo me");
        queue_line("RCPT TO:<a@b>");
        queue_line("MAIL FROM:x@y");
        queue_line("MAIL FROM:<@y>");
        queue_line("mail from:<x@y>");
        queue_line("DATA");
        queue_line("rcpt to:<x@>");
        queue_line("RCPT TO:<x@y>");
        queue_line("title hi");
        queue_line("DATA");
        queue_text(".\r\n");
        queue_text("\r\r\n");
        queue_line("QUIT");
        queue_text("HELO x\r\n");
        queue_text({8'hFF, 8'h00});
        wait_drained();

        // A message held back at the sender and then released at once.
        hold_rx = 1'b1;
        queue_start();
        queue_line("HELO h");
        queue_line("MAIL FROM:<a@b>");
        for (int i = 0; i < 3; i++)
        begin
            queue_line("RCPT TO:<c@d>");
        end
        queue_line("DATA");
        queue_text("x\r\n.\r\n");
        repeat (20) @(posedge clk);
        hold_rx = 1'b0;
        wait_drained();

        while (queued < 600)
        begin
            if (queued > 350 && queued < 470)
            begin
                rx_idle_pct = 0;
                tx_idle_pct = 0;
            end
            else
            begin
                rx_idle_pct = 28;
                tx_idle_pct = 28;
            end
            case ($urandom_range(9))
                0, 1, 2: queue_session();
                3: queue_random_byte();
                4: queue_start();
                default: queue_random_line();
            endcase
            while (pending_bytes.size() > 8)
            begin
                @(posedge clk);
            end
        end
        rx_idle_pct = 28;
        tx_idle_pct = 28;
        wait_drained();
        repeat (10) @(posedge clk);

        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
hdl/smtp_pkg.sv
hdl/smtp_in_if.sv
hdl/smtp_out_if.sv
hdl/smtp_front.sv
hdl/smtp_queue.sv
hdl/smtp_session_command_fsm.sv
hdl/smtp_checker.sv
sim/smtp_tb_if.sv
sim/smtp_session_command_fsm_tb.sv
